[src/lsm2d_pkg.sv]
package lsm2d_pkg;

    localparam int MAX_SET = 8;
    localparam int CNT_W = $clog2(MAX_SET + 1);

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TOO_FEW  = 2'd1;
    localparam logic [1:0] STATUS_SINGULAR = 2'd2;

    localparam int MAG_W = 103;
    localparam int DIV_CW = 7;

    // one beacon request as classified by the front part
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        d;
        logic               is_ref;
        logic               use_row;
        logic               last;
    } beacon_req_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [1:0]         status;
    } lsm_result_t;

endpackage

[src/lsm2d_front.sv]
module lsm2d_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,
    input  logic                 s_tlast,
    output logic                 q_valid,
    input  logic                 q_ready,
    output lsm2d_pkg::beacon_req_t q_req
);
    import lsm2d_pkg::*;

    // two-entry queue
    beacon_req_t q_mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic        push, pop;
    beacon_req_t req;

    assign s_tready = (fill_reg != 2'd2);
    assign push = s_tvalid && s_tready;
    assign q_valid = (fill_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_req = q_mem_reg[rd_ptr_reg];

    always_comb begin
        req.x = s_tdata[15:0];
        req.y = s_tdata[31:16];
        req.d = s_tdata[47:32];
        req.last = s_tlast;
        req.is_ref = (cnt_reg == '0);
        req.use_row = (cnt_reg != '0) && (cnt_reg < CNT_W'(MAX_SET));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                q_mem_reg[wr_ptr_reg] <= req;
                wr_ptr_reg <= ~wr_ptr_reg;
                if (s_tlast) cnt_reg <= '0;
                else if (cnt_reg < CNT_W'(MAX_SET)) cnt_reg <= cnt_reg + 1'b1;
            end
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg != 2'd3) else $error("queue fill out of range");
    a_ref_first: assert property (@(posedge aclk) disable iff (!aresetn)
        push && $past(push && s_tlast) |-> req.is_ref) else $error("set start missed");
    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_SET)) else $error("count over bound");

endmodule

[src/lsm2d_div.sv]
module lsm2d_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [lsm2d_pkg::MAG_W-1:0]   num,
    input  logic [lsm2d_pkg::MAG_W-1:0]   den,
    output logic                          done,
    output logic [lsm2d_pkg::MAG_W-1:0]   quot
);
    import lsm2d_pkg::*;

    // restoring divider, one quotient bit a cycle
    logic [MAG_W-1:0] rem_reg, q_reg, den_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [MAG_W:0] shifted, diff;

    assign shifted = {rem_reg, q_reg[MAG_W-1]};
    assign diff = shifted - {1'b0, den_reg};
    assign done = done_reg;
    assign quot = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                q_reg    <= num;
                den_reg  <= den;
                cnt_reg  <= DIV_CW'(MAG_W - 1);
            end else if (busy_reg) begin
                if (!diff[MAG_W]) begin
                    rem_reg <= diff[MAG_W-1:0];
                    q_reg   <= {q_reg[MAG_W-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted[MAG_W-1:0];
                    q_reg   <= {q_reg[MAG_W-2:0], 1'b0};
                end
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("start while busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("done held");

endmodule

[src/lsm2d_back.sv]
module lsm2d_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [39:0]              det_threshold,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  lsm2d_pkg::beacon_req_t   q_req,
    output logic                     r_valid,
    input  logic                     r_ready,
    output lsm2d_pkg::lsm_result_t   r_res
);
    import lsm2d_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_ROW1, S_ROW2, S_ROW3, S_ACC, S_FIN,
        S_D1, S_D2, S_D3, S_D4, S_CHK,
        S_N1, S_N2, S_N3, S_N4, S_N5, S_N6, S_NX,
        S_DIVX, S_WX, S_DIVY, S_WY, S_OUT
    } state_t;

    state_t state_reg;
    beacon_req_t cur_reg;
    logic signed [15:0] rx_reg, ry_reg;
    logic [15:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic signed [41:0] saxx_reg, saxy_reg, sayy_reg;
    logic signed [59:0] sabx_reg, saby_reg;
    logic signed [17:0] ax_reg, ay_reg;
    logic signed [35:0] b_reg;
    logic signed [127:0] acc_reg, det_reg, nx_reg, ny_reg;
    logic [MAG_W-1:0] dmag_reg;
    logic signed [127:0] prod_reg;
    logic [1:0] part_reg;
    logic signed [59:0] ma_reg;
    logic signed [41:0] mb_reg;
    logic r_valid_reg;
    lsm_result_t res_reg;
    logic div_start, div_done;
    logic [MAG_W-1:0] div_num, div_quot;
    logic signed [15:0] sat_q;
    logic neg_reg;

    // 60x42 product formed from 30x42 halves: low half first, then the high half shifted and added
    logic signed [30:0] ma_lo;
    logic signed [29:0] ma_hi;
    logic signed [72:0] pp;
    assign ma_lo = {1'b0, ma_reg[29:0]};
    assign ma_hi = ma_reg[59:30];
    assign pp = (part_reg == 2'd0) ? 73'(ma_lo * mb_reg) : 73'(ma_hi * mb_reg);

    assign q_ready = (state_reg == S_IDLE) && !r_valid_reg;
    assign r_valid = r_valid_reg;
    assign r_res = res_reg;

    lsm2d_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(dmag_reg), .done(div_done), .quot(div_quot)
    );

    assign div_start = (state_reg == S_DIVX) || (state_reg == S_DIVY);
    always_comb begin
        logic signed [127:0] n;
        n = (state_reg == S_DIVX) ? nx_reg : ny_reg;
        div_num = n[127] ? MAG_W'(-n) : MAG_W'(n);
    end

    always_comb begin
        if (!neg_reg)
            sat_q = (div_quot > MAG_W'(32767)) ? 16'sh7FFF : div_quot[15:0];
        else
            sat_q = (div_quot > MAG_W'(32768)) ? 16'sh8000 : 16'(-div_quot[15:0]);
    end

    task automatic load_mul(input logic signed [59:0] a, input logic signed [41:0] b);
        ma_reg <= a;
        mb_reg <= b;
        part_reg <= 2'd0;
    endtask

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            r_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            part_reg    <= 2'd2;
            saxx_reg <= '0; saxy_reg <= '0; sayy_reg <= '0;
            sabx_reg <= '0; saby_reg <= '0;
            rx_reg <= '0; ry_reg <= '0; rd_reg <= '0;
        end else begin
            if (r_valid_reg && r_ready) r_valid_reg <= 1'b0;
            if (part_reg != 2'd2) begin
                if (part_reg == 2'd0) prod_reg <= 128'(pp);
                else prod_reg <= prod_reg + (128'(pp) <<< 30);
                part_reg <= part_reg + 2'd1;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid && !r_valid_reg) begin
                        cur_reg <= q_req;
                        if (q_req.is_ref) begin
                            rx_reg <= q_req.x; ry_reg <= q_req.y; rd_reg <= q_req.d;
                            cnt_reg <= CNT_W'(1);
                            state_reg <= q_req.last ? S_FIN : S_IDLE;
                        end else if (q_req.use_row) begin
                            ax_reg <= 18'(2 * (19'(q_req.x) - 19'(rx_reg)));
                            ay_reg <= 18'(2 * (19'(q_req.y) - 19'(ry_reg)));
                            b_reg <= 36'($signed({1'b0, rd_reg}) * $signed({1'b0, rd_reg}))
                                   - 36'($signed({1'b0, q_req.d}) * $signed({1'b0, q_req.d}));
                            cnt_reg <= cnt_reg + 1'b1;
                            state_reg <= S_ROW1;
                        end else begin
                            state_reg <= q_req.last ? S_FIN : S_IDLE;
                        end
                    end
                end
                S_ROW1: begin
                    b_reg <= b_reg - 36'(rx_reg * rx_reg) + 36'(cur_reg.x * cur_reg.x);
                    state_reg <= S_ROW2;
                end
                S_ROW2: begin
                    b_reg <= b_reg - 36'(ry_reg * ry_reg) + 36'(cur_reg.y * cur_reg.y);
                    saxx_reg <= saxx_reg + 42'(ax_reg * ax_reg);
                    state_reg <= S_ROW3;
                end
                S_ROW3: begin
                    saxy_reg <= saxy_reg + 42'(ax_reg * ay_reg);
                    sayy_reg <= sayy_reg + 42'(ay_reg * ay_reg);
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    sabx_reg <= sabx_reg + 60'(ax_reg * b_reg);
                    saby_reg <= saby_reg + 60'(ay_reg * b_reg);
                    state_reg <= cur_reg.last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    res_reg.pos_x <= '0; res_reg.pos_y <= '0;
                    if (cnt_reg < CNT_W'(3)) begin
                        res_reg.status <= STATUS_TOO_FEW;
                        state_reg <= S_OUT;
                    end else begin
                        load_mul(60'(saxx_reg), sayy_reg);
                        state_reg <= S_D1;
                    end
                end
                S_D1: if (part_reg == 2'd2) begin
                    acc_reg <= prod_reg;
                    load_mul(60'(saxy_reg), saxy_reg);
                    state_reg <= S_D2;
                end
                S_D2: if (part_reg == 2'd2) begin
                    det_reg <= acc_reg - prod_reg;
                    state_reg <= S_D3;
                end
                S_D3: begin
                    dmag_reg <= det_reg[127] ? MAG_W'(-det_reg) : MAG_W'(det_reg);
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    if (dmag_reg == '0 || dmag_reg < MAG_W'(det_threshold)) begin
                        res_reg.status <= STATUS_SINGULAR;
                        state_reg <= S_OUT;
                    end else begin
                        res_reg.status <= STATUS_OK;
                        load_mul(sabx_reg, sayy_reg);
                        state_reg <= S_N1;
                    end
                end
                S_N1: if (part_reg == 2'd2) begin
                    acc_reg <= prod_reg;
                    load_mul(saby_reg, saxy_reg);
                    state_reg <= S_N2;
                end
                S_N2: if (part_reg == 2'd2) begin
                    nx_reg <= acc_reg - prod_reg;
                    load_mul(saby_reg, saxx_reg);
                    state_reg <= S_N3;
                end
                S_N3: if (part_reg == 2'd2) begin
                    acc_reg <= prod_reg;
                    load_mul(sabx_reg, saxy_reg);
                    state_reg <= S_N4;
                end
                S_N4: if (part_reg == 2'd2) begin
                    ny_reg <= acc_reg - prod_reg;
                    state_reg <= S_N5;
                end
                S_N5: begin
                    if (det_reg[127]) begin
                        nx_reg <= -nx_reg;
                        ny_reg <= -ny_reg;
                    end
                    state_reg <= S_N6;
                end
                S_N6: state_reg <= S_NX;
                S_NX: state_reg <= S_DIVX;
                S_DIVX: begin
                    neg_reg <= nx_reg[127];
                    state_reg <= S_WX;
                end
                S_WX: if (div_done) begin
                    res_reg.pos_x <= sat_q;
                    state_reg <= S_DIVY;
                end
                S_DIVY: begin
                    neg_reg <= ny_reg[127];
                    state_reg <= S_WY;
                end
                S_WY: if (div_done) begin
                    res_reg.pos_y <= sat_q;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    r_valid_reg <= 1'b1;
                    cnt_reg <= '0;
                    saxx_reg <= '0; saxy_reg <= '0; sayy_reg <= '0;
                    sabx_reg <= '0; saby_reg <= '0;
                    rx_reg <= '0; ry_reg <= '0; rd_reg <= '0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ready |-> state_reg == S_IDLE) else $error("accept while busy");
    a_status_ok_only: assert property (@(posedge aclk) disable iff (!aresetn)
        r_valid_reg && res_reg.status != STATUS_OK |-> res_reg.pos_x == '0)
        else $error("position on failed solve");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_SET)) else $error("count over bound");

endmodule

[src/least_squares_multilateration_2d_top.sv]
// 2-d least-squares multilateration: beacons arrive one request at a time, the first
// of a set is the reference and each later one up to the eighth beacon adds a linearised
// row to the normal equation sums; the request marked tlast yields one result (status 0
// ok, 1 too few beacons, 2 determinant magnitude below det_threshold or zero). in the
// back part a beacon passes through row products and sum updates; after the last row
// the solve time is set mostly by the 103-step restoring divider, run once per axis,
// which a set with too few beacons or a singular one skips. a two-entry queue lets the
// front take requests while the back works.
module least_squares_multilateration_2d_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // beacon_x, beacon_y, range_dist
    input  logic        s_tlast,   // last_beacon
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pos_x, pos_y
    output logic [1:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [39:0] cfg_data
);
    import lsm2d_pkg::*;

    logic [39:0] det_threshold_reg;
    logic q_valid, q_ready;
    beacon_req_t q_req;
    lsm_result_t res;

    // threshold register; the user must write it only while idle, the block does not enforce this
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) det_threshold_reg <= 40'd1;
        else if (cfg_valid) det_threshold_reg <= cfg_data;
    end

    lsm2d_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    lsm2d_back u_back (
        .aclk(aclk), .aresetn(aresetn), .det_threshold(det_threshold_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .r_valid(m_tvalid), .r_ready(m_tready), .r_res(res)
    );

    assign m_tdata = {res.pos_y, res.pos_x};
    assign m_tuser = res.status;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import lsm2d_pkg::*;

    // watchdog: cycles in a row without any handshake before the run is abandoned
    localparam int STALL_LIMIT = 20000;
    // quiet time before a register write and at the end, longer than one solve
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_ITEMS = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;     // beacon_x, beacon_y, range_dist
    logic        s_tlast = 1'b0;   // last_beacon
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // pos_x, pos_y
    logic [1:0]  m_tuser;          // status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [39:0] cfg_data = '0;

    least_squares_multilateration_2d_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // one row of the directed table; typed rows carry the status the result must show
    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] d;
        bit          last;
        bit          typed;
        logic [1:0]  st;
    } beacon_row_t;

    // mirror of the block's set state and its register
    logic [39:0] thr_mirror;
    longint      ref_x, ref_y, ref_d;
    int          held;
    longint      sum_axx, sum_axy, sum_ayy, sum_abx, sum_aby;

    lsm_result_t fix_q[$];         // positions still owed by the block
    int          mismatches = 0;
    int          sent = 0;
    bit          no_idle = 1'b0;   // stretch where neither side idles
    int          rx_hold = 0;      // receiver hold-off, counted down in its own process
    int          quiet_cnt = 0;

    function automatic logic [15:0] axis_code(input logic signed [127:0] num,
                                              input logic [127:0] dmag);
        logic [127:0] q;
        logic [127:0] nmag;
        nmag = num[127] ? 128'(-num) : 128'(num);
        q = nmag / dmag;
        if (!num[127])
            return (q > 128'd32767) ? 16'h7FFF : q[15:0];
        if (q > 128'd32768)
            return 16'h8000;
        return 16'(128'd0 - q);
    endfunction

    // folds one beacon into the set; returns 1 with the fix when the set ends
    function automatic bit solve_position(input logic [15:0] bx, input logic [15:0] by,
                                          input logic [15:0] bd, input bit last,
                                          output lsm_result_t r);
        longint x, y, d, ax, ay, b;
        logic signed [127:0] axx, axy, ayy, abx, aby, det, nx, ny;
        logic [127:0] dmag;
        x = longint'($signed(bx));
        y = longint'($signed(by));
        d = longint'({48'd0, bd});
        r = '0;
        if (held == 0) begin
            ref_x = x;
            ref_y = y;
            ref_d = d;
            held = 1;
        end else if (held < MAX_SET) begin
            ax = 2 * (x - ref_x);
            ay = 2 * (y - ref_y);
            b = ref_d * ref_d - d * d - ref_x * ref_x + x * x - ref_y * ref_y + y * y;
            sum_axx += ax * ax;
            sum_axy += ax * ay;
            sum_ayy += ay * ay;
            sum_abx += ax * b;
            sum_aby += ay * b;
            held++;
        end
        if (!last)
            return 1'b0;
        if (held < 3) begin
            r.status = STATUS_TOO_FEW;
        end else begin
            axx = sum_axx;
            axy = sum_axy;
            ayy = sum_ayy;
            abx = sum_abx;
            aby = sum_aby;
            det = axx * ayy - axy * axy;
            dmag = det[127] ? 128'(-det) : 128'(det);
            if (dmag == 0 || dmag < {88'd0, thr_mirror}) begin
                r.status = STATUS_SINGULAR;
            end else begin
                nx = abx * ayy - aby * axy;
                ny = aby * axx - abx * axy;
                if (det[127]) begin
                    nx = -nx;
                    ny = -ny;
                end
                r.pos_x = axis_code(nx, dmag);
                r.pos_y = axis_code(ny, dmag);
                r.status = STATUS_OK;
            end
        end
        held = 0;
        ref_x = 0; ref_y = 0; ref_d = 0;
        sum_axx = 0; sum_axy = 0; sum_ayy = 0; sum_abx = 0; sum_aby = 0;
        return 1'b1;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 35);
    endfunction

    // offers one beacon request; valid stays high between back-to-back requests
    task automatic send_beacon(input logic [15:0] bx, input logic [15:0] by,
                               input logic [15:0] bd, input bit last,
                               input bit typed, input logic [1:0] st);
        lsm_result_t r;
        bit got;
        while (idle_now()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {bd, by, bx};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        got = solve_position(bx, by, bd, last, r);
        if (got) begin
            // typed rows: positions are zero for both error statuses
            if (typed)
                r = '{pos_x: 16'sd0, pos_y: 16'sd0, status: st};
            fix_q.push_back(r);
        end
        sent++;
        @(negedge aclk);
    endtask

    task automatic pause_sender();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        @(negedge aclk);
    endtask

    // register write only once the block has nothing left to deliver
    task automatic write_threshold(input logic [39:0] value);
        pause_sender();
        wait (fix_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        thr_mirror = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // one random set: mostly consistent geometry around a true point, some noise
    task automatic random_set();
        int n, kind, i;
        int px, py, bx, by, dd;
        real range_est;
        kind = $urandom_range(99);
        if (kind < 10)
            n = $urandom_range(1, 2);
        else if (kind < 20)
            n = $urandom_range(MAX_SET + 1, MAX_SET + 4);
        else
            n = $urandom_range(3, 6);
        px = $urandom_range(8000) - 4000;
        py = $urandom_range(8000) - 4000;
        for (i = 0; i < n; i++) begin
            if (kind >= 85) begin
                // raw full-range fields
                send_beacon(16'($urandom), 16'($urandom), 16'($urandom),
                            i == n - 1, 1'b0, STATUS_OK);
            end else begin
                bx = $urandom_range(16000) - 8000;
                by = $urandom_range(16000) - 8000;
                range_est = $sqrt(real'((bx - px) * (bx - px) + (by - py) * (by - py)));
                dd = $rtoi(range_est) + $urandom_range(64) - 32;
                if (dd < 0)
                    dd = 0;
                send_beacon(16'(bx), 16'(by), 16'(dd), i == n - 1, 1'b0, STATUS_OK);
            end
        end
    endtask

    beacon_row_t dir_tab[] = '{
        // single beacon closes the set
        '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, STATUS_TOO_FEW},
        // two beacons only
        '{16'h0100, 16'h0000, 16'h0200, 1'b0, 1'b0, STATUS_OK},
        '{16'h0200, 16'h0000, 16'h0100, 1'b1, 1'b1, STATUS_TOO_FEW},
        // collinear on the x axis, zero determinant
        '{16'h0000, 16'h0000, 16'h0400, 1'b0, 1'b0, STATUS_OK},
        '{16'h0100, 16'h0000, 16'h0300, 1'b0, 1'b0, STATUS_OK},
        '{16'h0200, 16'h0000, 16'h0200, 1'b1, 1'b1, STATUS_SINGULAR},
        // field extremes
        '{16'h8000, 16'h8000, 16'hFFFF, 1'b0, 1'b0, STATUS_OK},
        '{16'h7FFF, 16'h8000, 16'h0000, 1'b0, 1'b0, STATUS_OK},
        '{16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, 1'b0, STATUS_OK},
        // square around a point, normal solve
        '{16'h0000, 16'h0000, 16'h0B50, 1'b0, 1'b0, STATUS_OK},
        '{16'h0A00, 16'h0000, 16'h0800, 1'b0, 1'b0, STATUS_OK},
        '{16'h0000, 16'h0A00, 16'h0800, 1'b0, 1'b0, STATUS_OK},
        '{16'h0A00, 16'h0A00, 16'h0300, 1'b1, 1'b0, STATUS_OK},
        // more than the bound: later beacons ignored, last still ends the set
        '{16'h0000, 16'h0000, 16'h0100, 1'b0, 1'b0, STATUS_OK},
        '{16'h0300, 16'h0100, 16'h0200, 1'b0, 1'b0, STATUS_OK},
        '{16'h0100, 16'h0500, 16'h0300, 1'b0, 1'b0, STATUS_OK},
        '{16'hFD00, 16'h0200, 16'h0400, 1'b0, 1'b0, STATUS_OK},
        '{16'h0200, 16'hFC00, 16'h0500, 1'b0, 1'b0, STATUS_OK},
        '{16'hF800, 16'hF900, 16'h0600, 1'b0, 1'b0, STATUS_OK},
        '{16'h0700, 16'h0600, 16'h0700, 1'b0, 1'b0, STATUS_OK},
        '{16'h0400, 16'hFE00, 16'h0800, 1'b0, 1'b0, STATUS_OK},
        '{16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0, 1'b0, STATUS_OK},
        '{16'h8000, 16'h8000, 16'h0000, 1'b1, 1'b0, STATUS_OK},
        // three identical beacons, zero determinant
        '{16'h1234, 16'hEDCB, 16'h0500, 1'b0, 1'b0, STATUS_OK},
        '{16'h1234, 16'hEDCB, 16'h0500, 1'b0, 1'b0, STATUS_OK},
        '{16'h1234, 16'hEDCB, 16'h0500, 1'b1, 1'b1, STATUS_SINGULAR}
    };

    // receiver: random back-pressure, or a counted hold-off when asked
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_tready <= aresetn && !idle_now();
        end
    end

    // result checker: oldest expected fix against each accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (fix_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: pos_x=%0d pos_y=%0d status=%0d",
                             $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tuser);
            end else begin
                if (m_tdata[15:0] !== fix_q[0].pos_x || m_tdata[31:16] !== fix_q[0].pos_y
                        || m_tuser !== fix_q[0].status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%0d y=%0d st=%0d, got x=%0d y=%0d st=%0d",
                                 fix_q[0].pos_x, fix_q[0].pos_y, fix_q[0].status,
                                 $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tuser);
                end
                void'(fix_q.pop_front());
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        thr_mirror = 40'd1;
        held = 0;
        ref_x = 0; ref_y = 0; ref_d = 0;
        sum_axx = 0; sum_axy = 0; sum_ayy = 0; sum_abx = 0; sum_aby = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table at the reset threshold
        foreach (dir_tab[i])
            send_beacon(dir_tab[i].x, dir_tab[i].y, dir_tab[i].d, dir_tab[i].last,
                        dir_tab[i].typed, dir_tab[i].st);

        // zero threshold: only an exact zero determinant is singular
        write_threshold(40'd0);
        send_beacon(16'h0000, 16'h0000, 16'h0100, 1'b0, 1'b0, STATUS_OK);
        send_beacon(16'h0100, 16'h0000, 16'h0100, 1'b0, 1'b0, STATUS_OK);
        send_beacon(16'h0000, 16'h0000, 16'h0100, 1'b1, 1'b1, STATUS_SINGULAR);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= 300 && sent < 320) begin
                // top threshold: only sets with a large determinant magnitude are solved
                write_threshold(40'hFF_FFFF_FFFF);
                sent = 320;
            end else if (sent >= 600 && sent < 620) begin
                write_threshold(40'($urandom) << $urandom_range(8));
                sent = 620;
            end else if (sent >= 900 && sent < 920) begin
                // long receiver hold-off while requests keep coming
                rx_hold = 3000;
                sent = 920;
            end else if (sent >= 1200 && sent < 1220) begin
                // sender waits for every owed fix
                pause_sender();
                wait (fix_q.size() == 0);
                no_idle = 1'b1;
                sent = 1220;
            end else if (sent >= 1450 && sent < 1470) begin
                no_idle = 1'b0;
                write_threshold(40'd1);
                sent = 1470;
            end else if (sent >= 1700 && sent < 1720) begin
                write_threshold({8'($urandom_range(255)), 32'd0});
                sent = 1720;
            end
            random_set();
        end
        pause_sender();

        wait (fix_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && fix_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[least_squares_multilateration_2d_top.f]
src/lsm2d_pkg.sv
src/lsm2d_front.sv
src/lsm2d_div.sv
src/lsm2d_back.sv
src/least_squares_multilateration_2d_top.sv
verif/tb_top.sv
